// ===== rtl/sgb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the semitone coefficient table of the Goertzel bank.
// No dependencies; sgb_mag, the bank top and the testbench import it.
package sgb_pkg;

    localparam int BIN_COUNT_DEF       = 96;
    localparam int BINS_PER_RESULT_DEF = 8;
    localparam int STATE_BITS_DEF      = 48;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int MAG_W      = 32;
    localparam int GROUP_W    = 4;
    localparam int MAG_SLOTS  = 8;
    localparam int MAX_GROUPS = 12;
    localparam int COEF_DEPTH = 96;
    localparam int FRAC_SHIFT = 16;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] RATIO_DEN = 64'd32000000000000;

    localparam logic [63:0] SEMITONE_RATIO [12] = '{
        64'd10000000000, 64'd10594630944, 64'd11224620483, 64'd11892071150,
        64'd12599210499, 64'd13348398542, 64'd14142135624, 64'd14983070769,
        64'd15874010520, 64'd16817928305, 64'd17817974363, 64'd18877486254
    };

    typedef logic signed [COEF_W-1:0] coef_rom_t [COEF_DEPTH];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MREAD,
        ST_MSTART,
        ST_MBUSY,
        ST_MEMIT,
        ST_CLEAR
    } sgb_state_t;

    typedef enum logic [2:0] {
        MG_IDLE,
        MG_PROD,
        MG_WAIT,
        MG_PSAT,
        MG_FIN,
        MG_ROOT,
        MG_DONE
    } sgb_mag_state_t;

    // Shift-subtract division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 2cos(omega) in Q2.16 for one semitone bin, integer Taylor evaluation
    function automatic logic signed [COEF_W-1:0] semitone_coef(input int idx);
        logic [63:0] t;
        logic [63:0] rem;
        logic [63:0] v;
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] cu;
        logic signed [63:0] cs;
        int          k;
        int          oct;
        k   = idx;
        oct = 0;
        for (int m = 0; m < 8; m++) begin
            if (k >= 12) begin
                k   = k - 12;
                oct = oct + 1;
            end
        end
        t   = (SEMITONE_RATIO[k] * 64'd11) << oct;
        rem = t;
        for (int m = 0; m < 4; m++) begin
            if (rem >= RATIO_DEN) rem = rem - RATIO_DEN;
        end
        v = '0;
        for (int n = 0; n < 30; n++) begin
            rem = rem << 1;
            v   = v << 1;
            if (rem >= RATIO_DEN) begin
                rem  = rem - RATIO_DEN;
                v[0] = 1'b1;
            end
        end
        theta  = (v * PI_Q30) >> 32;
        theta2 = (theta * theta) >> 28;
        term   = 64'd1 << 28;
        sum    = term;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * theta2) >> 28, 64'((2 * n - 1) * (2 * n)));
            if ((n % 2) == 1) sum = sum - term;
            else sum = sum + term;
        end
        cu = ((sum << 1) + (64'd1 << 30) + (64'd1 << 11)) >> 12;
        cs = $signed(cu) - 64'sd262144;
        if (cs > 64'sd131071) cs = 64'sd131071;
        if (cs < -64'sd131072) cs = -64'sd131072;
        return cs[COEF_W-1:0];
    endfunction

    function automatic coef_rom_t build_coef_rom();
        coef_rom_t rom;
        for (int i = 0; i < COEF_DEPTH; i++) rom[i] = semitone_coef(i);
        return rom;
    endfunction

    localparam coef_rom_t COEF_ROM = build_coef_rom();

endpackage

// ===== rtl/sgb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 96
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sgb_mag.sv =====
`timescale 1ns / 1ps
// Magnitude unit: q1^2 + q2^2 - c*q1*q2 through one shared 32x32 multiplier,
// then a bit-pair integer square root. Depends on sgb_pkg.
module sgb_mag import sgb_pkg::*; #(
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [COEF_W-1:0]     coef,
    input  logic signed [STATE_BITS-1:0] q1,
    input  logic signed [STATE_BITS-1:0] q2,
    output logic                         done,
    output logic [MAG_W-1:0]             mag
);

    localparam int ACC_W = 130;

    sgb_mag_state_t state_reg, state_next;

    logic [1:0]  term_reg, term_next;
    logic [1:0]  part_reg, part_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [63:0] abs_c_reg, abs_q1_reg, abs_q2_reg, abs_p_reg;
    logic        sc_reg, s1_reg, s2_reg, sp_reg;

    logic [63:0] prod_reg;
    logic [1:0]  pshift_reg;
    logic        pneg_reg;
    logic        pv_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic [63:0]             x_reg;
    logic [35:0]             rem_reg;
    logic [MAG_W-1:0]        root_reg;
    logic [MAG_W-1:0]        mag_reg;

    logic signed [63:0]  q1_w, q2_w;
    logic signed [63:0]  coef_w;
    logic [63:0]         a_full, b_full;
    logic [31:0]         a_chunk, b_chunk;
    logic                neg_sel;
    logic [ACC_W-1:0]    ext;
    logic signed [63:0]  p_sat;
    logic [35:0]         rem_t;
    logic [35:0]         trial;
    logic                fit;

    assign q1_w   = 64'(q1);
    assign q2_w   = 64'(q2);
    assign coef_w = 64'(coef);

    // Pick operands of the current product term
    always_comb begin
        case (term_reg)
            2'd0: begin
                a_full  = abs_c_reg;
                b_full  = abs_q1_reg;
                neg_sel = sc_reg ^ s1_reg;
            end
            2'd1: begin
                a_full  = abs_q1_reg;
                b_full  = abs_q1_reg;
                neg_sel = 1'b0;
            end
            2'd2: begin
                a_full  = abs_q2_reg;
                b_full  = abs_q2_reg;
                neg_sel = 1'b0;
            end
            default: begin
                a_full  = abs_p_reg;
                b_full  = abs_q2_reg;
                neg_sel = ~(sp_reg ^ s2_reg);
            end
        endcase
        a_chunk = part_reg[1] ? a_full[63:32] : a_full[31:0];
        b_chunk = part_reg[0] ? b_full[63:32] : b_full[31:0];
    end

    assign ext = ACC_W'(prod_reg) << {pshift_reg, 5'b0};

    // Saturate the shifted c*q1 to signed 64 bits
    always_comb begin
        if (&acc_reg[ACC_W-1:79] || ~|acc_reg[ACC_W-1:79]) p_sat = acc_reg[79:16];
        else if (acc_reg[ACC_W-1]) p_sat = {1'b1, 63'b0};
        else p_sat = {1'b0, {63{1'b1}}};
    end

    assign rem_t = {rem_reg[33:0], x_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fit   = rem_t >= trial;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        unique case (state_reg)
            MG_IDLE: begin
                if (start) begin
                    state_next = MG_PROD;
                    term_next  = 2'd0;
                    part_next  = 2'd0;
                end
            end
            MG_PROD: begin
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd3) state_next = MG_WAIT;
            end
            MG_WAIT: begin
                if (term_reg == 2'd0) begin
                    state_next = MG_PSAT;
                end else if (term_reg == 2'd3) begin
                    state_next = MG_FIN;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = MG_PROD;
                end
            end
            MG_PSAT: begin
                term_next  = 2'd1;
                state_next = MG_PROD;
            end
            MG_FIN: begin
                cnt_next = 5'd31;
                if (acc_reg[ACC_W-1] || (|acc_reg[ACC_W-1:80])) state_next = MG_DONE;
                else state_next = MG_ROOT;
            end
            MG_ROOT: begin
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) state_next = MG_DONE;
            end
            MG_DONE: begin
                done       = 1'b1;
                state_next = MG_IDLE;
            end
            default: state_next = MG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MG_IDLE;
            term_reg  <= 2'd0;
            part_reg  <= 2'd0;
            cnt_reg   <= 5'd0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            part_reg  <= part_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= (state_reg == MG_PROD);
        end
    end

    // Datapath: operand capture, multiply, accumulate, root
    always_ff @(posedge aclk) begin
        prod_reg   <= a_chunk * b_chunk;
        pshift_reg <= 2'(part_reg[1]) + 2'(part_reg[0]);
        pneg_reg   <= neg_sel;

        if (state_reg == MG_IDLE && start) begin
            abs_c_reg  <= coef_w[63] ? -coef_w : coef_w;
            abs_q1_reg <= q1_w[63] ? -q1_w : q1_w;
            abs_q2_reg <= q2_w[63] ? -q2_w : q2_w;
            sc_reg     <= coef_w[63];
            s1_reg     <= q1_w[63];
            s2_reg     <= q2_w[63];
            acc_reg    <= '0;
        end else if (state_reg == MG_PSAT) begin
            abs_p_reg <= p_sat[63] ? -p_sat : p_sat;
            sp_reg    <= p_sat[63];
            acc_reg   <= '0;
        end else if (pv_reg) begin
            acc_reg <= pneg_reg ? acc_reg - $signed(ext) : acc_reg + $signed(ext);
        end

        if (state_reg == MG_FIN) begin
            x_reg    <= acc_reg[79:16];
            rem_reg  <= '0;
            root_reg <= '0;
            if (acc_reg[ACC_W-1]) mag_reg <= '0;
            else if (|acc_reg[ACC_W-1:80]) mag_reg <= '1;
        end else if (state_reg == MG_ROOT) begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= fit ? rem_t - trial : rem_t;
            root_reg <= {root_reg[MAG_W-2:0], fit};
            if (cnt_reg == 5'd0) mag_reg <= {root_reg[MAG_W-2:0], fit};
        end
    end

    assign mag = mag_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == MG_IDLE)
        else $error("magnitude unit started while busy");

    a_prod_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> $past(state_reg == MG_PROD))
        else $error("partial product without an issue");

    a_done_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(state_reg == MG_FIN) || $past(state_reg == MG_ROOT))
        else $error("result without a finish step");

endmodule

// ===== rtl/semitone_goertzel_bank.sv =====
`timescale 1ns / 1ps
// Semitone Goertzel bank: one pass per sample through the
// state RAM (one bin per cycle over its read/write port pair).
// On a block end, each bin then goes through the shared magnitude unit
// (read, start, the multiplier passes, a 32-step square root and the handoff).
// A group item goes out every 8 bins, after an emit step that waits for the output register to be free.
// Reset: synchronous, active low; control clears, bin state reads as zero from reset.
// Depends on sgb_pkg, sgb_ram and sgb_mag.
module semitone_goertzel_bank import sgb_pkg::*; #(
    parameter int BIN_COUNT       = BIN_COUNT_DEF,
    parameter int BINS_PER_RESULT = BINS_PER_RESULT_DEF,
    parameter int STATE_BITS      = STATE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_block_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [GROUP_W-1:0]         m_group_index,
    output logic [MAG_W-1:0]           m_mag_0,
    output logic [MAG_W-1:0]           m_mag_1,
    output logic [MAG_W-1:0]           m_mag_2,
    output logic [MAG_W-1:0]           m_mag_3,
    output logic [MAG_W-1:0]           m_mag_4,
    output logic [MAG_W-1:0]           m_mag_5,
    output logic [MAG_W-1:0]           m_mag_6,
    output logic [MAG_W-1:0]           m_mag_7,
    output logic                       m_final_group
);

    localparam int ADDR_W      = $clog2(BIN_COUNT);
    localparam int CNT_W       = $clog2(BIN_COUNT + 1);
    localparam int SLOT_W      = $clog2(MAG_SLOTS);
    localparam int GROUP_COUNT = (BIN_COUNT + BINS_PER_RESULT - 1) / BINS_PER_RESULT;
    localparam int REP_GROUPS  = (GROUP_COUNT < MAX_GROUPS) ? GROUP_COUNT : MAX_GROUPS;
    localparam int REP_RAW     = REP_GROUPS * BINS_PER_RESULT;
    localparam int REP_BINS    = (REP_RAW < BIN_COUNT) ? REP_RAW : BIN_COUNT;
    localparam int LO_W        = STATE_BITS / 2;
    localparam int HI_W        = STATE_BITS - LO_W;
    localparam int PROD_W      = COEF_W + STATE_BITS;
    localparam int RAM_W       = 2 * STATE_BITS;

    sgb_state_t state_reg, state_next;

    logic [CNT_W-1:0]   bin_reg, bin_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [GROUP_W-1:0] group_reg, group_next;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       end_reg;

    logic              v1_reg, v2_reg;
    logic [ADDR_W-1:0] a1_reg, a2_reg;
    logic              rd_ok_reg;
    logic [BIN_COUNT-1:0] valid_reg;

    logic signed [COEF_W-1:0]       coef_reg;
    logic signed [COEF_W+LO_W:0]    pp_lo_reg;
    logic signed [COEF_W+HI_W-1:0]  pp_hi_reg;
    logic signed [STATE_BITS-1:0]   q1_s2_reg, q2_s2_reg;

    logic              rd_en, wr_en, zero_wr;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [RAM_W-1:0]  rd_data, wr_data;

    logic signed [STATE_BITS-1:0] q1_rd, q2_rd;
    logic signed [COEF_W+LO_W:0]   pp_lo;
    logic signed [COEF_W+HI_W-1:0] pp_hi;
    logic signed [PROD_W-1:0]     hi_ext, lo_ext, full, sh, q2_ext, x_ext, sum;
    logic [STATE_BITS-1:0]        rec;

    logic             mag_start, mag_done;
    logic [MAG_W-1:0] mag_result;
    logic             load_out;

    logic [MAG_W-1:0]   mag_slot_reg [MAG_SLOTS];
    logic               m_valid_reg;
    logic [GROUP_W-1:0] group_index_reg;
    logic [MAG_W-1:0]   mag_out_reg [MAG_SLOTS];
    logic               final_reg;

    // State RAM: q1 in the upper half, q2 in the lower half
    sgb_ram #(
        .WIDTH(RAM_W),
        .DEPTH(BIN_COUNT)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Never-written bins read as zero
    assign q1_rd = rd_ok_reg ? rd_data[RAM_W-1:STATE_BITS] : '0;
    assign q2_rd = rd_ok_reg ? rd_data[STATE_BITS-1:0] : '0;

    // Recurrence stage 1: split c*q1 into two narrow products
    assign pp_lo = coef_reg * $signed({1'b0, q1_rd[LO_W-1:0]});
    assign pp_hi = coef_reg * $signed(q1_rd[STATE_BITS-1:LO_W]);

    // Recurrence stage 2: combine, floor shift, subtract q2, add sample, saturate
    assign hi_ext = PROD_W'(pp_hi_reg);
    assign lo_ext = PROD_W'(pp_lo_reg);
    assign full   = (hi_ext <<< LO_W) + lo_ext;
    assign sh     = full >>> FRAC_SHIFT;
    assign q2_ext = PROD_W'(q2_s2_reg);
    assign x_ext  = PROD_W'($signed({x_reg, 8'b0}));
    assign sum    = sh - q2_ext + x_ext;

    always_comb begin
        if (&sum[PROD_W-1:STATE_BITS-1] || ~|sum[PROD_W-1:STATE_BITS-1]) begin
            rec = sum[STATE_BITS-1:0];
        end else if (sum[PROD_W-1]) begin
            rec = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            rec = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    end

    // Write port: recurrence results, or zeros while the block is cleared
    assign wr_en   = v2_reg || zero_wr;
    assign wr_addr = v2_reg ? a2_reg : bin_reg[ADDR_W-1:0];
    assign wr_data = v2_reg ? {rec, q1_s2_reg} : '0;
    assign rd_addr = bin_reg[ADDR_W-1:0];

    // Control sequencer
    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        slot_next  = slot_reg;
        group_next = group_reg;
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        zero_wr    = 1'b0;
        mag_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    bin_next   = '0;
                    slot_next  = '0;
                    group_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                rd_en = 1'b1;
                if (bin_reg == CNT_W'(BIN_COUNT - 1)) begin
                    bin_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    bin_next = bin_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) state_next = end_reg ? ST_MREAD : ST_IDLE;
            end
            ST_MREAD: begin
                if (bin_reg < CNT_W'(REP_BINS)) begin
                    rd_en      = 1'b1;
                    state_next = ST_MSTART;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_MSTART: begin
                mag_start  = 1'b1;
                zero_wr    = 1'b1;
                state_next = ST_MBUSY;
            end
            ST_MBUSY: begin
                if (mag_done) begin
                    bin_next = bin_reg + 1'b1;
                    if (slot_reg == SLOT_W'(BINS_PER_RESULT - 1) ||
                        bin_reg == CNT_W'(REP_BINS - 1)) begin
                        state_next = ST_MEMIT;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_MREAD;
                    end
                end
            end
            ST_MEMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    group_next = group_reg + 1'b1;
                    slot_next  = '0;
                    state_next = ST_MREAD;
                end
            end
            ST_CLEAR: begin
                if (bin_reg == CNT_W'(BIN_COUNT)) begin
                    state_next = ST_IDLE;
                end else begin
                    zero_wr  = 1'b1;
                    bin_next = bin_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Shared magnitude unit
    sgb_mag #(
        .STATE_BITS(STATE_BITS)
    ) u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mag_start),
        .coef    (coef_reg),
        .q1      (q1_rd),
        .q2      (q2_rd),
        .done    (mag_done),
        .mag     (mag_result)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bin_reg     <= '0;
            slot_reg    <= '0;
            group_reg   <= '0;
            end_reg     <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            rd_ok_reg   <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAG_SLOTS; i++) mag_slot_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            slot_reg  <= slot_next;
            group_reg <= group_next;
            if (s_valid && s_ready) end_reg <= s_block_end;
            v1_reg    <= rd_en && (state_reg == ST_RUN);
            v2_reg    <= v1_reg;
            rd_ok_reg <= valid_reg[rd_addr];
            if (wr_en) valid_reg[wr_addr] <= 1'b1;
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            // Collect magnitudes, then drop them once the group item is loaded
            if (load_out) begin
                for (int i = 0; i < MAG_SLOTS; i++) mag_slot_reg[i] <= '0;
            end else if (state_reg == ST_MBUSY && mag_done) begin
                mag_slot_reg[slot_reg] <= mag_result;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) x_reg <= s_sample;
        coef_reg  <= COEF_ROM[rd_addr];
        a1_reg    <= rd_addr;
        a2_reg    <= a1_reg;
        pp_lo_reg <= pp_lo;
        pp_hi_reg <= pp_hi;
        q1_s2_reg <= q1_rd;
        q2_s2_reg <= q2_rd;
        if (load_out) begin
            group_index_reg <= group_reg;
            final_reg       <= (group_reg == GROUP_W'(REP_GROUPS - 1));
            for (int i = 0; i < MAG_SLOTS; i++) mag_out_reg[i] <= mag_slot_reg[i];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_group_index = group_index_reg;
    assign m_final_group = final_reg;
    assign m_mag_0       = mag_out_reg[0];
    assign m_mag_1       = mag_out_reg[1];
    assign m_mag_2       = mag_out_reg[2];
    assign m_mag_3       = mag_out_reg[3];
    assign m_mag_4       = mag_out_reg[4];
    assign m_mag_5       = mag_out_reg[5];
    assign m_mag_6       = mag_out_reg[6];
    assign m_mag_7       = mag_out_reg[7];

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !v1_reg && !v2_reg)
        else $error("sample taken while the recurrence pipeline is busy");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_final_group) |-> m_group_index == GROUP_W'(REP_GROUPS - 1))
        else $error("final flag on a group that is not the last");

    a_done_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_done |-> state_reg == ST_MBUSY)
        else $error("magnitude result arrived outside the wait state");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(BINS_PER_RESULT - 1))
        else $error("slot index beyond the group size");

endmodule

// ===== bench/semitone_goertzel_bank_tb.sv =====
`timescale 1ns / 1ps
// Testbench for semitone_goertzel_bank: an in-bench Goertzel predictor is run on each
// accepted sample, and every group item is checked field by field against it.
// Depends on sgb_pkg and the semitone_goertzel_bank RTL.
module semitone_goertzel_bank_tb;
    import sgb_pkg::*;

    localparam int NBINS   = 96;
    localparam int NGROUPS = 12;

    typedef struct {
        logic [GROUP_W-1:0] grp;
        logic [MAG_W-1:0]   mag [MAG_SLOTS];
        logic               fin;
    } group_mags_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       s_block_end = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [GROUP_W-1:0]         m_group_index;
    logic [MAG_W-1:0]           m_mag [MAG_SLOTS];
    logic                       m_final_group;

    logic signed [47:0] bin_q1 [NBINS];
    logic signed [47:0] bin_q2 [NBINS];
    logic signed [17:0] bin_coef [NBINS];
    group_mags_t        pending_groups [$];
    int                 mismatches = 0;
    int                 hold_cycles = 0;

    semitone_goertzel_bank uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample), .s_block_end(s_block_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_group_index(m_group_index),
        .m_mag_0(m_mag[0]), .m_mag_1(m_mag[1]), .m_mag_2(m_mag[2]), .m_mag_3(m_mag[3]),
        .m_mag_4(m_mag[4]), .m_mag_5(m_mag[5]), .m_mag_6(m_mag[6]), .m_mag_7(m_mag[7]),
        .m_final_group(m_final_group)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // 2cos(omega) in Q2.16 from an integer Taylor series
    function automatic logic signed [17:0] semitone_cos2(input int idx);
        logic [63:0] t, rem, v, th, th2, term, cu;
        logic signed [63:0] sum, cs;
        t = (SEMITONE_RATIO[idx % 12] * 64'd11) << (idx / 12);
        rem = t % RATIO_DEN;
        v = '0;
        for (int n = 0; n < 30; n++) begin
            rem = rem << 1;
            v = v << 1;
            if (rem >= RATIO_DEN) begin
                rem = rem - RATIO_DEN;
                v[0] = 1'b1;
            end
        end
        th = (v * PI_Q30) >> 32;
        th2 = (th * th) >> 28;
        term = 64'd1 << 28;
        sum = $signed(term);
        for (int n = 1; n <= 24; n++) begin
            term = ((term * th2) >> 28) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        cu = (64'(sum * 2) + (64'd1 << 30) + (64'd1 << 11)) >> 12;
        cs = $signed(cu) - 64'sd262144;
        if (cs > 64'sd131071) cs = 64'sd131071;
        if (cs < -64'sd131072) cs = -64'sd131072;
        return cs[17:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] bin_mag(input int b);
        logic signed [127:0] q1w, q2w, cw, p, m;
        q1w = bin_q1[b];
        q2w = bin_q2[b];
        cw = bin_coef[b];
        p = (cw * q1w) >>> 16;
        m = q1w * q1w + q2w * q2w - p * q2w;
        if (m < 0) return '0;
        m = m >>> 16;
        if (m[127:64] != 0) return 32'hFFFF_FFFF;
        return MAG_W'(int_sqrt(m[63:0]));
    endfunction

    // Advance every bin by one sample; on block end queue the group items and clear
    task automatic goertzel_advance(input logic signed [15:0] x, input logic be);
        logic signed [127:0] s, q1w, q2w, cw, xw;
        group_mags_t gm;
        for (int b = 0; b < NBINS; b++) begin
            q1w = bin_q1[b];
            q2w = bin_q2[b];
            cw = bin_coef[b];
            xw = x;
            s = ((cw * q1w) >>> 16) - q2w + (xw <<< 8);
            bin_q2[b] = bin_q1[b];
            if (s > 128'sh7FFF_FFFF_FFFF) bin_q1[b] = 48'sh7FFF_FFFF_FFFF;
            else if (s < -128'sh8000_0000_0000) bin_q1[b] = 48'sh8000_0000_0000;
            else bin_q1[b] = s[47:0];
        end
        if (be) begin
            for (int g = 0; g < NGROUPS; g++) begin
                gm.grp = GROUP_W'(g);
                for (int j = 0; j < MAG_SLOTS; j++) gm.mag[j] = bin_mag(g * MAG_SLOTS + j);
                gm.fin = (g == NGROUPS - 1);
                pending_groups.push_back(gm);
            end
            for (int b = 0; b < NBINS; b++) begin
                bin_q1[b] = '0;
                bin_q2[b] = '0;
            end
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one sample at the falling edge; hold it until accepted
    task automatic send_sample(input logic [15:0] x, input logic be, input bit no_gap);
        int gap;
        s_sample = x;
        s_block_end = be;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        goertzel_advance(x, be);
        @(negedge aclk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drive ready: long hold when requested, otherwise random stalls
    initial begin : ready_driver
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    // Check each group item against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_groups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected group item: group %0d", m_group_index);
            end else begin
                group_mags_t gm;
                bit bad;
                gm = pending_groups.pop_front();
                bad = (gm.grp != m_group_index) || (gm.fin != m_final_group);
                for (int j = 0; j < MAG_SLOTS; j++) if (gm.mag[j] != m_mag[j]) bad = 1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp group %0d final %0b, got group %0d final %0b",
                                 gm.grp, gm.fin, m_group_index, m_final_group);
                        for (int j = 0; j < MAG_SLOTS; j++)
                            $display("  mag_%0d exp %0d got %0d", j, gm.mag[j], m_mag[j]);
                    end
                end
            end
        end
    end

    // Extremes, one-sample blocks, alternating full scale
    task automatic test_directed();
        send_sample(16'sd32767, 1'b1, 0);
        send_sample(-16'sd32768, 1'b1, 0);
        send_sample(16'sd0, 1'b1, 0);
        for (int i = 0; i < 8; i++) send_sample(16'sd32767, i == 7, 1);
        for (int i = 0; i < 10; i++)
            send_sample(i[0] ? -16'sd32768 : 16'sd32767, i == 9, 0);
        send_sample(16'shAAAA, 1'b0, 0);
        send_sample(16'h5555, 1'b1, 0);
    endtask

    // Random blocks: mostly tone-like square waves, with random noise samples mixed in
    task automatic test_random_blocks(input int n_items);
        int sent, len, per;
        logic [15:0] amp;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            per = $urandom_range(1, 40);
            amp = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) send_sample(16'($urandom), i == len - 1, 0);
                else send_sample(((i / per) % 2) ? -amp : amp, i == len - 1, 0);
            end
            sent += len;
        end
    endtask

    // Hold the receiver off while samples keep coming, so the input stalls
    task automatic test_backpressure();
        hold_cycles = 30000;
        for (int b = 0; b < 3; b++)
            for (int i = 0; i < 6; i++) send_sample(16'($urandom), i == 5, 1);
    endtask

    initial begin : stimulus
        int waited;
        for (int b = 0; b < NBINS; b++) begin
            bin_coef[b] = semitone_cos2(b);
            bin_q1[b] = '0;
            bin_q2[b] = '0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_backpressure();
        test_random_blocks(310);
        s_valid = 1'b0;
        waited = 0;
        while (pending_groups.size() != 0 && waited < 400000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (200) @(negedge aclk);
        if (mismatches == 0 && pending_groups.size() == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #300ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
